### rtl/wmof_pkg.sv
`default_nettype none

package wmof_pkg;

    localparam int CHANNELS = 6;
    localparam int WINDOW   = 20;

    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 32;
    localparam int ABS_W    = 31;
    localparam int FRAC_W   = 16;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 2;

    // per-channel counters
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PTR_W = $clog2(WINDOW);

    // ring store and double-banked sorted store
    localparam int WIN_DEPTH  = CHANNELS * WINDOW;
    localparam int WIN_AW     = $clog2(WIN_DEPTH);
    localparam int SORT_DEPTH = 2 * WIN_DEPTH;
    localparam int SORT_AW    = $clog2(SORT_DEPTH);

    localparam int PROD_W = SAMPLE_W + FRAC_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REL_FRAC  = 2'd2;

    localparam logic [CHANNELS-1:0] MODE_MASK_RST = CHANNELS'(56);
    localparam logic [ABS_W-1:0]    ABS_THR_RST   = ABS_W'(3277);
    localparam logic [FRAC_W-1:0]   REL_FRAC_RST  = FRAC_W'(3277);

    typedef struct packed {
        logic                valid;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] median;
        logic                rel;
    } judge_req_t;

    typedef struct packed {
        logic                valid;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] filtered;
        logic                replaced;
    } judge_res_t;

    function automatic logic [WIN_AW-1:0] win_addr(input logic [CH_W-1:0] ch,
                                                  input logic [PTR_W-1:0] slot);
        return WIN_AW'(WIN_AW'(ch) * WIN_AW'(WINDOW)) + WIN_AW'(slot);
    endfunction

    function automatic logic [SORT_AW-1:0] sort_addr(input logic bank,
                                                    input logic [CH_W-1:0] ch,
                                                    input logic [PTR_W-1:0] slot);
        logic [SORT_AW-1:0] base;
        base = bank ? SORT_AW'(WIN_DEPTH) : '0;
        return base + SORT_AW'(SORT_AW'(ch) * SORT_AW'(WINDOW)) + SORT_AW'(slot);
    endfunction

endpackage

`default_nettype wire

### rtl/wmof_if.sv
`default_nettype none

interface wmof_in_if import wmof_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, channel, sample, input ready);
    modport sink   (input valid, channel, sample, output ready);
endinterface

interface wmof_out_if import wmof_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       replaced;

    modport source (output valid, out_channel, filtered, replaced, input ready);
    modport sink   (input valid, out_channel, filtered, replaced, output ready);
endinterface

`default_nettype wire

### rtl/wmof_judge.sv
`default_nettype none

module wmof_judge import wmof_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire judge_req_t        req,
    input  wire logic [ABS_W-1:0]  abs_thr,
    input  wire logic [FRAC_W-1:0] rel_frac,
    output judge_res_t             res
);

    logic [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]   diff_neg;
    logic [SAMPLE_W:0]   med_ext;
    logic [SAMPLE_W:0]   med_neg;
    logic [SAMPLE_W-1:0] dev;
    logic [SAMPLE_W-1:0] mag;

    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_dev_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic                s1_rel_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [SAMPLE_W-1:0] s1_median_reg;

    logic [SAMPLE_W-1:0] thr;
    logic                reject;

    logic                res_valid_reg;
    logic [CH_W-1:0]     res_ch_reg;
    logic [SAMPLE_W-1:0] res_filtered_reg;
    logic                res_replaced_reg;

    // exact 33-bit deviation and median magnitude
    always_comb
    begin
        med_ext  = {req.median[SAMPLE_W-1], req.median};
        diff     = {req.sample[SAMPLE_W-1], req.sample} - med_ext;
        diff_neg = '0 - diff;
        med_neg  = '0 - med_ext;
        dev      = diff[SAMPLE_W] ? diff_neg[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];
        mag      = med_ext[SAMPLE_W] ? med_neg[SAMPLE_W-1:0] : med_ext[SAMPLE_W-1:0];
    end

    always_comb
    begin
        thr    = s1_rel_reg ? s1_prod_reg[PROD_W-1:FRAC_W] : {1'b0, abs_thr};
        reject = s1_dev_reg > thr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= req.valid;
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            s1_dev_reg    <= dev;
            s1_prod_reg   <= PROD_W'(mag) * PROD_W'(rel_frac);
            s1_rel_reg    <= req.rel;
            s1_ch_reg     <= req.ch;
            s1_sample_reg <= req.sample;
            s1_median_reg <= req.median;
        end
        if (s1_valid_reg)
        begin
            res_ch_reg       <= s1_ch_reg;
            res_filtered_reg <= reject ? s1_median_reg : s1_sample_reg;
            res_replaced_reg <= reject;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.ch       = res_ch_reg;
    assign res.filtered = res_filtered_reg;
    assign res.replaced = res_replaced_reg;

endmodule

`default_nettype wire

### rtl/window_median_outlier_filter.sv
// sliding-window median outlier filter, six channels
// in_req (sink): one request carries a channel number and a signed Q16.16
// sample, taken when valid and ready are both high; ready is high only while
// the block is idle. a request for a channel at or above CHANNELS is taken and
// dropped: no state changes and no result follows.
// out_res (source): one result per kept request: the channel, the filtered
// value (sample, or the window median when the sample is an outlier) and the
// replaced flag, in request order.
// cfg: plain write port, cfg_we with cfg_index and cfg_data, one register per
// edge; write only while idle.
// each channel keeps its samples in a ring memory and a sorted copy of its
// window in a second, double-banked memory. a request walks the sorted copy
// once, dropping the evicted sample and merging in the new one, one entry per
// cycle; the entry at position count/2 is the median. after the walk the
// request passes the judge, then loads the output register; the next request
// is taken the cycle after the result is loaded.
// reset clears counters, ring pointers and bank selects, not the memories. a
// stalled receiver holds the result in the output register; one finished
// request waits behind it, and no new request is taken until it moves.
`default_nettype none

module window_median_outlier_filter import wmof_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    wmof_in_if.sink                   in_req,
    wmof_out_if.source                out_res,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MERGE = 5'b00010,
        ST_JUDGE = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [CHANNELS-1:0] mode_reg;
    logic [ABS_W-1:0]    abs_thr_reg;
    logic [FRAC_W-1:0]   rel_frac_reg;

    // per-channel window bookkeeping
    logic [CNT_W-1:0] fill_reg [CHANNELS];
    logic [PTR_W-1:0] ptr_reg  [CHANNELS];
    logic [CHANNELS-1:0] bank_reg;

    // current request
    logic [CH_W-1:0]            ch_reg;
    logic signed [SAMPLE_W-1:0] s_reg;
    logic [CNT_W-1:0]           n_old_reg;
    logic [CNT_W-1:0]           n_new_reg;
    logic                       full_reg;

    // merge walk
    logic [CNT_W-1:0]           i_reg, i_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic                       removed_reg, removed_next;
    logic                       inserted_reg, inserted_next;
    logic signed [SAMPLE_W-1:0] med_reg, med_next;
    logic                       have_x;
    logic                       merge_done;

    // memories
    logic signed [SAMPLE_W-1:0] win_mem  [WIN_DEPTH];
    logic signed [SAMPLE_W-1:0] sort_mem [SORT_DEPTH];
    logic signed [SAMPLE_W-1:0] win_q;
    logic signed [SAMPLE_W-1:0] sort_q;
    logic [WIN_AW-1:0]          win_a;
    logic [SORT_AW-1:0]         sort_ra;
    logic [SORT_AW-1:0]         sort_wa;
    logic                       sort_we;
    logic signed [SAMPLE_W-1:0] sort_wd;

    // request decode in idle
    logic             in_ok;
    logic [CH_W-1:0]  in_ch;
    logic             accept;
    logic             take_new;
    logic [CNT_W-1:0] in_fill;
    logic             in_full;
    logic [PTR_W-1:0] in_slot;
    logic [PTR_W-1:0] rd_slot;

    // judge and output
    judge_req_t          jreq;
    judge_res_t          jres;
    logic                out_load;
    logic                out_valid_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic [SAMPLE_W-1:0] out_filtered_reg;
    logic                out_replaced_reg;

    assign in_ok    = in_req.channel < CH_W'(CHANNELS);
    assign in_ch    = in_ok ? in_req.channel : '0;
    assign accept   = in_req.valid && in_req.ready;
    assign take_new = accept && in_ok;
    assign in_fill  = fill_reg[in_ch];
    assign in_full  = in_fill == CNT_W'(WINDOW);
    assign in_slot  = in_full ? ptr_reg[in_ch] : in_fill[PTR_W-1:0];

    assign in_req.ready = state_reg == ST_IDLE;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_MASK_RST;
            abs_thr_reg  <= ABS_THR_RST;
            rel_frac_reg <= REL_FRAC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE_MASK: mode_reg     <= cfg_data[CHANNELS-1:0];
                REG_ABS_THR:   abs_thr_reg  <= cfg_data[ABS_W-1:0];
                REG_REL_FRAC:  rel_frac_reg <= cfg_data[FRAC_W-1:0];
                default:       ;
            endcase
        end
    end

    // merge step: skip the evicted value once, put the new sample ahead of the
    // first entry not smaller than it, otherwise copy the current entry to the other bank
    assign have_x = i_reg < n_old_reg;

    always_comb
    begin
        i_next        = i_reg;
        k_next        = k_reg;
        removed_next  = removed_reg;
        inserted_next = inserted_reg;
        med_next      = med_reg;
        sort_we       = 1'b0;
        sort_wd       = s_reg;
        merge_done    = 1'b0;
        if (state_reg == ST_MERGE)
        begin
            if (full_reg && !removed_reg && have_x && sort_q == win_q)
            begin
                removed_next = 1'b1;
                i_next       = i_reg + CNT_W'(1);
            end
            else if (!inserted_reg && (!have_x || s_reg <= sort_q))
            begin
                sort_we       = 1'b1;
                sort_wd       = s_reg;
                inserted_next = 1'b1;
            end
            else if (have_x)
            begin
                sort_we = 1'b1;
                sort_wd = sort_q;
                i_next  = i_reg + CNT_W'(1);
            end
            if (sort_we)
            begin
                k_next = k_reg + CNT_W'(1);
                if (k_reg == (n_new_reg >> 1))
                begin
                    med_next = sort_wd;
                end
                merge_done = k_next == n_new_reg;
            end
        end
    end

    // read the sorted copy one entry ahead; first entry is fetched at accept
    assign rd_slot = (i_next < CNT_W'(WINDOW)) ? i_next[PTR_W-1:0] : '0;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            sort_ra = sort_addr(bank_reg[in_ch], in_ch, '0);
        end
        else
        begin
            sort_ra = sort_addr(bank_reg[ch_reg], ch_reg, rd_slot);
        end
    end

    assign sort_wa = sort_addr(!bank_reg[ch_reg], ch_reg, k_reg[PTR_W-1:0]);
    assign win_a   = win_addr(in_ch, in_slot);

    // ring store: the evicted sample is read while the new one is written
    always_ff @(posedge clk)
    begin
        if (take_new)
        begin
            win_q          <= win_mem[win_a];
            win_mem[win_a] <= in_req.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sort_we)
        begin
            sort_mem[sort_wa] <= sort_wd;
        end
        sort_q <= sort_mem[sort_ra];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_new)
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (merge_done)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (jres.valid)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bank_reg      <= '0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            removed_reg   <= 1'b0;
            inserted_reg  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                fill_reg[c] <= '0;
                ptr_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (take_new)
            begin
                i_reg        <= '0;
                k_reg        <= '0;
                removed_reg  <= 1'b0;
                inserted_reg <= 1'b0;
            end
            else
            begin
                i_reg        <= i_next;
                k_reg        <= k_next;
                removed_reg  <= removed_next;
                inserted_reg <= inserted_next;
            end
            // window bookkeeping commits with the last merge write
            if (merge_done)
            begin
                bank_reg[ch_reg] <= !bank_reg[ch_reg];
                if (!full_reg)
                begin
                    fill_reg[ch_reg] <= fill_reg[ch_reg] + CNT_W'(1);
                end
                else if (ptr_reg[ch_reg] == PTR_W'(WINDOW - 1))
                begin
                    ptr_reg[ch_reg] <= '0;
                end
                else
                begin
                    ptr_reg[ch_reg] <= ptr_reg[ch_reg] + PTR_W'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_new)
        begin
            ch_reg    <= in_ch;
            s_reg     <= in_req.sample;
            n_old_reg <= in_fill;
            n_new_reg <= in_full ? in_fill : in_fill + CNT_W'(1);
            full_reg  <= in_full;
        end
        med_reg <= med_next;
        if (out_load)
        begin
            out_ch_reg       <= jres.ch;
            out_filtered_reg <= jres.filtered;
            out_replaced_reg <= jres.replaced;
        end
    end

    // threshold compare
    assign jreq.valid  = state_reg == ST_JUDGE;
    assign jreq.ch     = ch_reg;
    assign jreq.sample = s_reg;
    assign jreq.median = med_reg;
    assign jreq.rel    = mode_reg[ch_reg];

    wmof_judge u_judge (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (jreq),
        .abs_thr  (abs_thr_reg),
        .rel_frac (rel_frac_reg),
        .res      (jres)
    );

    assign out_res.valid       = out_valid_reg;
    assign out_res.out_channel = out_ch_reg;
    assign out_res.filtered    = out_filtered_reg;
    assign out_res.replaced    = out_replaced_reg;

    // merge never writes past the new window count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MERGE |-> k_reg < n_new_reg)
        else $error("merge write index beyond window count");

    // the new sample is always placed before the walk ends
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_JUDGE |-> inserted_reg)
        else $error("merge finished without the new sample");

    // a window that was not full never drops an entry
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_JUDGE && !full_reg |-> !removed_reg)
        else $error("entry dropped from a window that was not full");

    // judge result arrives only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        jres.valid |-> state_reg == ST_WAIT)
        else $error("judge result outside wait state");

    // bookkeeping stays in range for the channel being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> ch_reg < CH_W'(CHANNELS) && fill_reg[ch_reg] <= CNT_W'(WINDOW))
        else $error("channel or fill count out of range");

endmodule

`default_nettype wire
